// ===== rtl/core/mxe_pkg.sv =====
// ----------------------------------------------------------------------------
// mxe_pkg
// Shared types and codes for the integer matrix add, subtract and multiply
// engine: command, status, operation and register codes, and the state type.
// ----------------------------------------------------------------------------
package mxe_pkg;

   // Field widths fixed by the interface.
   localparam int DATA_W     = 32;
   localparam int DIM_W      = 5;
   localparam int IDX_W      = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   // Request commands.
   localparam logic [1:0] CMD_WR_A = 2'd0;
   localparam logic [1:0] CMD_WR_B = 2'd1;
   localparam logic [1:0] CMD_REQ  = 2'd2;

   // Response status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DIMS  = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   // Operation codes; the undefined code acts as multiply.
   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_OP_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_A_ROWS  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_A_COLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_B_ROWS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_B_COLS  = 3'd4;

   // Reset value of every dimension register.
   localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/core/mxe_ram.sv =====
// ----------------------------------------------------------------------------
// mxe_ram
// Generic simple dual-port RAM: one write port and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module mxe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/matrix_add_sub_mul_engine_core.sv =====
// ----------------------------------------------------------------------------
// matrix_add_sub_mul_engine_core
// Holds two signed 32-bit matrices A and B in synchronous RAMs and returns
// one element of A+B, A-B or A*B for each result request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake            Moves
//   req_      in          req_valid/req_ready  write of A or B, or a request
//   rsp_      out         rsp_valid/rsp_ready  status, row, column and value
//   csr_      in          csr_we               op_mode and the dimensions
//
// A write of A or B gives no response.
// A request issues n reads of each store in RUN, one multiply-accumulate
// per cycle, where n is 1 for add or subtract and a_cols (capped at MAX_DIM)
// for multiply; the input reopens once DONE loads the response. A failed
// dimension or range check, or an empty inner dimension, skips RUN and goes
// straight to DONE. Reset is synchronous; the stores are not cleared.
// While a response waits on rsp_ready the block still takes writes and
// starts the next request, which then holds until the output register frees.
// ----------------------------------------------------------------------------
module matrix_add_sub_mul_engine_core #(
   parameter int MAX_DIM = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_cmd,
   input  logic [mxe_pkg::IDX_W-1:0]           req_row,
   input  logic [mxe_pkg::IDX_W-1:0]           req_col,
   input  logic signed [mxe_pkg::DATA_W-1:0]   req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [mxe_pkg::IDX_W-1:0]           rsp_out_row,
   output logic [mxe_pkg::IDX_W-1:0]           rsp_out_col,
   output logic signed [mxe_pkg::DATA_W-1:0]   rsp_out_value,
   input  logic                                csr_we,
   input  logic [mxe_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mxe_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = mxe_pkg::DIM_W;
   localparam int XW    = mxe_pkg::DATA_W;

   // Dimension saturated to the store size.
   function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] d);
      eff_dim = (32'(d) > 32'(MAX_DIM)) ? DW'(MAX_DIM) : d;
   endfunction

   // Store address of an element, row major.
   function automatic logic [AW-1:0] cell_addr(input logic [DW-1:0] r,
                                               input logic [DW-1:0] c);
      cell_addr = AW'(32'(r) * 32'(MAX_DIM) + 32'(c));
   endfunction

   // Configuration registers.
   logic [1:0]    op_mode_ff;
   logic [DW-1:0] a_rows_ff, a_cols_ff, b_rows_ff, b_cols_ff;

   // Sequencer and pipeline control.
   mxe_pkg::state_type state_ff, state_in;
   logic          rd_vld_ff, rd_vld_in;
   logic          prod_vld_ff, prod_vld_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          issue, load_out;

   // Request context and datapath.
   logic [DW-1:0] row_ff, row_in, col_ff, col_in;
   logic [DW-1:0] k_ff, k_in, len_ff, len_in;
   logic          mul_ff, mul_in, sub_ff, sub_in;
   logic [1:0]    status_ff, status_in;
   logic [XW-1:0] prod_ff, prod_in, acc_ff, acc_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [mxe_pkg::IDX_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [XW-1:0] rsp_value_ff, rsp_value_in;

   // Request decode.
   logic          req_take, take_cmd, wr_ok, last_issue;
   logic          cur_mul;
   logic [DW-1:0] ar, ac, br, bc, req_row_x, req_col_x, cur_len;
   logic [1:0]    cur_status;

   // RAM ports.
   logic          a_we, b_we;
   logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
   logic [XW-1:0] a_rd_data, b_rd_data;

   // Accepted request and its checks against the configured shapes.
   always_comb begin
      req_take  = req_valid && req_ready;
      req_row_x = DW'(req_row);
      req_col_x = DW'(req_col);
      ar        = eff_dim(a_rows_ff);
      ac        = eff_dim(a_cols_ff);
      br        = eff_dim(b_rows_ff);
      bc        = eff_dim(b_cols_ff);
      // The top bit of op_mode selects multiply, so the undefined code does too.
      cur_mul   = op_mode_ff[1];
      take_cmd  = req_take && (req_cmd == mxe_pkg::CMD_REQ);
      if (cur_mul) begin
         cur_len = ac;
         if (ac != br) begin
            cur_status = mxe_pkg::STAT_DIMS;
         end else if (req_row_x >= ar || req_col_x >= bc) begin
            cur_status = mxe_pkg::STAT_RANGE;
         end else begin
            cur_status = mxe_pkg::STAT_OK;
         end
      end else begin
         cur_len = DW'(1);
         if (ar != br || ac != bc) begin
            cur_status = mxe_pkg::STAT_DIMS;
         end else if (req_row_x >= ar || req_col_x >= ac) begin
            cur_status = mxe_pkg::STAT_RANGE;
         end else begin
            cur_status = mxe_pkg::STAT_OK;
         end
      end
   end

   // Store writes; a position outside the store is dropped.
   always_comb begin
      wr_ok   = (32'(req_row) < 32'(MAX_DIM)) && (32'(req_col) < 32'(MAX_DIM));
      a_we    = req_take && wr_ok && (req_cmd == mxe_pkg::CMD_WR_A);
      b_we    = req_take && wr_ok && (req_cmd == mxe_pkg::CMD_WR_B);
      wr_addr = cell_addr(req_row_x, req_col_x);
   end

   // Read addresses: a row of A against a column of B, or the element itself.
   always_comb begin
      if (mul_ff) begin
         a_rd_addr = cell_addr(row_ff, k_ff);
         b_rd_addr = cell_addr(k_ff, col_ff);
      end else begin
         a_rd_addr = cell_addr(row_ff, col_ff);
         b_rd_addr = cell_addr(row_ff, col_ff);
      end
   end

   mxe_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_we),
      .wr_addr (wr_addr),
      .wr_data (XW'(unsigned'(req_value))),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mxe_ram #(.WIDTH(XW), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_we),
      .wr_addr (wr_addr),
      .wr_data (XW'(unsigned'(req_value))),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   // Next state.
   always_comb begin
      last_issue = (k_ff == len_ff - DW'(1));
      state_in   = state_ff;
      case (state_ff)
         mxe_pkg::ST_IDLE: begin
            if (take_cmd) begin
               if (cur_status == mxe_pkg::STAT_OK && cur_len != '0) begin
                  state_in = mxe_pkg::ST_RUN;
               end else begin
                  state_in = mxe_pkg::ST_DONE;
               end
            end
         end
         mxe_pkg::ST_RUN: begin
            if (last_issue) begin
               state_in = mxe_pkg::ST_DRAIN;
            end
         end
         mxe_pkg::ST_DRAIN: begin
            if (!rd_vld_ff && !prod_vld_ff) begin
               state_in = mxe_pkg::ST_DONE;
            end
         end
         mxe_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = mxe_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mxe_pkg::ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      issue     = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         mxe_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         mxe_pkg::ST_RUN: begin
            issue = 1'b1;
         end
         mxe_pkg::ST_DRAIN: begin
            issue = 1'b0;
         end
         mxe_pkg::ST_DONE: begin
            load_out = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath next values: read, combine, accumulate, then present.
   always_comb begin
      rd_vld_in   = issue;
      prod_vld_in = rd_vld_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      mul_in      = mul_ff;
      sub_in      = sub_ff;
      len_in      = len_ff;
      status_in   = status_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      if (take_cmd) begin
         row_in    = req_row_x;
         col_in    = req_col_x;
         mul_in    = cur_mul;
         sub_in    = (op_mode_ff == mxe_pkg::OP_SUB);
         len_in    = cur_len;
         status_in = cur_status;
         k_in      = '0;
         acc_in    = '0;
      end else begin
         if (issue) begin
            k_in = k_ff + DW'(1);
         end
         if (prod_vld_ff) begin
            acc_in = acc_ff + prod_ff;
         end
      end
      // Only the low 32 bits of the product are kept.
      if (mul_ff) begin
         prod_in = a_rd_data * b_rd_data;
      end else if (sub_ff) begin
         prod_in = a_rd_data - b_rd_data;
      end else begin
         prod_in = a_rd_data + b_rd_data;
      end
      rsp_status_in = rsp_status_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_value_in  = rsp_value_ff;
      if (load_out) begin
         rsp_status_in = status_ff;
         rsp_row_in    = mxe_pkg::IDX_W'(row_ff);
         rsp_col_in    = mxe_pkg::IDX_W'(col_ff);
         rsp_value_in  = acc_ff;
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mxe_pkg::ST_IDLE;
         rd_vld_ff    <= 1'b0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         op_mode_ff   <= mxe_pkg::OP_ADD;
         a_rows_ff    <= mxe_pkg::DIM_RESET;
         a_cols_ff    <= mxe_pkg::DIM_RESET;
         b_rows_ff    <= mxe_pkg::DIM_RESET;
         b_cols_ff    <= mxe_pkg::DIM_RESET;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         prod_vld_ff  <= prod_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               mxe_pkg::REG_OP_MODE: op_mode_ff <= csr_wdata[1:0];
               mxe_pkg::REG_A_ROWS:  a_rows_ff  <= csr_wdata;
               mxe_pkg::REG_A_COLS:  a_cols_ff  <= csr_wdata;
               mxe_pkg::REG_B_ROWS:  b_rows_ff  <= csr_wdata;
               mxe_pkg::REG_B_COLS:  b_cols_ff  <= csr_wdata;
               default: begin
                  op_mode_ff <= op_mode_ff;
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      row_ff        <= row_in;
      col_ff        <= col_in;
      mul_ff        <= mul_in;
      sub_ff        <= sub_in;
      len_ff        <= len_in;
      status_ff     <= status_in;
      k_ff          <= k_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_row   = rsp_row_ff;
   assign rsp_out_col   = rsp_col_ff;
   assign rsp_out_value = signed'(rsp_value_ff);

endmodule

// ===== rtl/core/mxe_checker.sv =====
// ----------------------------------------------------------------------------
// mxe_checker
// Port-level checks for the matrix engine, bound to the top level.
// ----------------------------------------------------------------------------
module mxe_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic [1:0]                        req_cmd,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [1:0]                        rsp_status,
   input logic [mxe_pkg::IDX_W-1:0]         rsp_out_row,
   input logic [mxe_pkg::IDX_W-1:0]         rsp_out_col,
   input logic signed [mxe_pkg::DATA_W-1:0] rsp_out_value
);

   // No response is pending straight after reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_out_value))
      else $error("stalled response changed");

   // A failed request answers with a zero value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mxe_pkg::STAT_OK |-> rsp_out_value == '0)
      else $error("error response carries a value");

   // Taking a result request closes the input until it is answered.
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_cmd == mxe_pkg::CMD_REQ |=> !req_ready)
      else $error("input open while a request is in flight");

endmodule

bind matrix_add_sub_mul_engine_core mxe_checker u_mxe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_cmd       (req_cmd),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_status    (rsp_status),
   .rsp_out_row   (rsp_out_row),
   .rsp_out_col   (rsp_out_col),
   .rsp_out_value (rsp_out_value)
);
